@@ rtl/core/glc_pkg.sv @@
`default_nettype none

package glc_pkg;

    localparam int CP_W    = 21;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [CP_W-1:0]  code_point;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               replaced_valid;
        logic [CP_W-1:0]    replaced_code_point;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } dp_ctl_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/glc_ctrl.sv @@
`default_nettype none

module glc_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic [glc_pkg::CMD_W-1:0] req_command,
    output logic                           req_stall,
    input  wire glc_pkg::dp_stat_t         stat,
    output glc_pkg::dp_ctl_t               ctl
);
    import glc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   needs_scan;

    assign needs_scan = (req_command == CMD_LOOKUP) || (req_command == CMD_INSERT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall  = 1'b1;
        ctl.load   = 1'b0;
        ctl.rd_en  = 1'b0;
        ctl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                ctl.load  = req_valid;
            end
            ST_SCAN:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                ctl.rd_en = 1'b0;
            end
            ST_FINISH:
            begin
                ctl.commit = stat.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/glc_datapath.sv @@
`default_nettype none

module glc_datapath #(
    parameter int ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire glc_pkg::req_t     req,
    input  wire glc_pkg::dp_ctl_t  ctl,
    output glc_pkg::dp_stat_t      stat,
    input  wire logic              rsp_stall,
    output logic                   rsp_valid,
    output glc_pkg::rsp_t          rsp
);
    import glc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [CP_W-1:0]    tag_mem   [ENTRIES];
    logic [COUNT_W-1:0] stamp_mem [ENTRIES];

    logic [CMD_W-1:0]   cmd_reg;
    logic [CP_W-1:0]    cp_reg;

    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rdv_reg;
    logic [IDX_W-1:0]   idx_d_reg;
    logic [CP_W-1:0]    tag_rd_reg;
    logic [COUNT_W-1:0] stamp_rd_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               best_have_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [COUNT_W-1:0] best_stamp_reg;
    logic [CP_W-1:0]    best_tag_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [COUNT_W-1:0] use_reg;
    logic [COUNT_W-1:0] use_next;
    logic [COUNT_W-1:0] hit_reg;
    logic [COUNT_W-1:0] hit_next;
    logic [COUNT_W-1:0] miss_reg;
    logic [COUNT_W-1:0] miss_next;

    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               entry_v;
    logic               take_match;
    logic               take_free;
    logic               take_best;
    logic [COUNT_W-1:0] use_inc;
    logic [IDX_W-1:0]   victim;
    logic [IDX_W-1:0]   wr_addr;
    logic               tag_we;
    logic               stamp_we;

    assign stat.scan_last = (rd_idx_reg == LAST_IDX);
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req.command;
            cp_reg  <= req.code_point;
        end
    end

    // Entry walk: one tag and stamp read per cycle, read data registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rdv_reg    <= 1'b0;
        end
        else
        begin
            rdv_reg <= ctl.rd_en;
            if (ctl.load)
            begin
                rd_idx_reg <= '0;
            end
            else if (ctl.rd_en && (rd_idx_reg != LAST_IDX))
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            tag_rd_reg   <= tag_mem[rd_idx_reg];
            stamp_rd_reg <= stamp_mem[rd_idx_reg];
            idx_d_reg    <= rd_idx_reg;
        end
        if (tag_we)
        begin
            tag_mem[wr_addr] <= cp_reg;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_addr] <= use_inc;
        end
    end

    assign entry_v    = valid_reg[idx_d_reg];
    assign take_match = rdv_reg && !found_reg && entry_v && (tag_rd_reg == cp_reg);
    assign take_free  = rdv_reg && !free_found_reg && !entry_v;
    assign take_best  = rdv_reg && entry_v
                        && (!best_have_reg || (stamp_rd_reg < best_stamp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_have_reg  <= 1'b0;
        end
        else if (ctl.load)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_have_reg  <= 1'b0;
        end
        else
        begin
            if (take_match)
            begin
                found_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (take_best)
            begin
                best_have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            found_idx_reg <= idx_d_reg;
        end
        if (take_free)
        begin
            free_idx_reg <= idx_d_reg;
        end
        if (take_best)
        begin
            best_idx_reg   <= idx_d_reg;
            best_stamp_reg <= stamp_rd_reg;
            best_tag_reg   <= tag_rd_reg;
        end
    end

    assign use_inc = use_reg + 1'b1;
    // An empty entry always wins over eviction.
    assign victim  = free_found_reg ? free_idx_reg : best_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        use_next   = use_reg;
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        wr_addr    = victim;
        tag_we     = 1'b0;
        stamp_we   = 1'b0;
        rsp_next   = '0;
        unique case (cmd_reg)
            CMD_LOOKUP:
            begin
                if (found_reg)
                begin
                    wr_addr       = found_idx_reg;
                    stamp_we      = ctl.commit;
                    use_next      = use_inc;
                    hit_next      = hit_reg + 1'b1;
                    rsp_next.hit  = 1'b1;
                    rsp_next.slot = SLOT_W'(found_idx_reg);
                end
                else
                begin
                    miss_next = miss_reg + 1'b1;
                end
            end
            CMD_INSERT:
            begin
                tag_we                       = ctl.commit;
                stamp_we                     = ctl.commit;
                valid_next[victim]           = 1'b1;
                use_next                     = use_inc;
                rsp_next.slot                = SLOT_W'(victim);
                rsp_next.replaced_valid      = !free_found_reg;
                rsp_next.replaced_code_point = free_found_reg ? '0 : best_tag_reg;
            end
            CMD_CLEAR:
            begin
                valid_next = '0;
                hit_next   = '0;
                miss_next  = '0;
            end
            default:
            begin
                use_next = use_reg;
            end
        endcase
        rsp_next.hit_total  = hit_next;
        rsp_next.miss_total = miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            use_reg       <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                valid_reg     <= valid_next;
                use_reg       <= use_next;
                hit_reg       <= hit_next;
                miss_reg      <= miss_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/glyph_lru_cache_directory_core.sv @@
// Lookup and insert walk all ENTRIES tags and stamps, one memory read per cycle,
// in ST_SCAN, then pass ST_DRAIN to ST_FINISH, where the response is registered
// once the output is free; a new request is taken only back in ST_IDLE. Clear and
// no-op requests go from ST_IDLE straight to ST_FINISH. The response register lets
// a new request start while the last response is still stalled.
// Reset clears the valid bits and the use, hit and miss counters at once.
`default_nettype none

module glyph_lru_cache_directory_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire glc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output glc_pkg::rsp_t      rsp
);
    import glc_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    glc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .req_stall   (req_stall),
        .stat        (stat),
        .ctl         (ctl)
    );

    glc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
